>>> rtl/vn2d_pkg.sv
// shared types and constants of the 2d value noise unit
// no dependencies; imported by vn2d_hash and value_noise_2d_unit
package vn2d_pkg;

   typedef logic [31:0] word_type;
   typedef logic [23:0] value_type;
   typedef logic [15:0] q16_type;
   typedef logic [16:0] q16_ext_type;
   typedef logic [32:0] weight_type;
   typedef logic [55:0] term_type;

   localparam word_type HASH_MUL_X  = 32'h9E37_79B9;
   localparam word_type HASH_MUL_Y  = 32'h85EB_CA6B;
   localparam word_type HASH_MIX_A  = 32'h7FEB_352D;
   localparam word_type HASH_MIX_B  = 32'h846C_A68B;

   localparam q16_ext_type Q16_ONE   = 17'h1_0000;
   localparam logic [17:0] Q16_THREE = 18'h3_0000;

   localparam int NUM_CORNERS = 4;
   localparam int LATENCY     = 8;

endpackage

>>> rtl/vn2d_hash.sv
// four-stage pipelined multiply-xorshift hash of one lattice corner
// depends on vn2d_pkg; result is the low 24 bits of the hash
module vn2d_hash (
   input  logic               clock,
   input  vn2d_pkg::word_type px_term,
   input  vn2d_pkg::word_type py_term,
   input  vn2d_pkg::word_type seed,
   output vn2d_pkg::value_type corner_value
);
   import vn2d_pkg::*;

   word_type  mix_in;
   word_type  mix_ff;
   logic [63:0] prod_a;
   word_type  mul_a_ff;
   word_type  mix_b;
   logic [63:0] prod_b;
   word_type  mul_b_ff;
   word_type  fold;
   value_type val_ff;

   always_comb begin
      mix_in = seed ^ px_term ^ py_term;
      mix_in = mix_in ^ (mix_in >> 16);
   end

   assign prod_a = 64'(mix_ff) * 64'(HASH_MIX_A);
   assign mix_b  = mul_a_ff ^ (mul_a_ff >> 15);
   assign prod_b = 64'(mix_b) * 64'(HASH_MIX_B);
   assign fold   = mul_b_ff ^ (mul_b_ff >> 16);

   always_ff @(posedge clock) begin
      mix_ff   <= mix_in;
      mul_a_ff <= prod_a[31:0];
      mul_b_ff <= prod_b[31:0];
      val_ff   <= fold[23:0];
   end

   assign corner_value = val_ff;

endmodule

>>> rtl/value_noise_2d_unit.sv
// top level of the 2d value noise unit: smoothstep-eased bilinear blend
// depends on vn2d_pkg and vn2d_hash (one instance per lattice corner)
//
// usage:
//   an item is taken at a rising edge with start high and busy low; busy is
//   high only while reset is asserted, so outside reset one item per clock
//   is taken. the item carries a signed fixed point point (req_x_coord,
//   req_y_coord, FRAC_BITS fraction bits) and a seed (req_seed_word).
//   each item gives one result: rsp_noise_value, unsigned Q0.24, shown for
//   one cycle with rsp_valid high, in the order the items came in.
//   throughput is one item per cycle, set by the eight-stage pipeline
//   (hash multiplies, easing multiplies, weight products and the two-level
//   adder tree each own a register stage).
//   the receiver cannot hold results off, so the pipeline never stalls.
//   a synchronous reset clears the valid bits; items in flight are dropped
//   and no result appears until new items are taken.
module value_noise_2d_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [31:0]   req_x_coord,
   input  logic signed [31:0]   req_y_coord,
   input  vn2d_pkg::word_type   req_seed_word,
   output logic                 rsp_valid,
   output vn2d_pkg::value_type  rsp_noise_value
);
   import vn2d_pkg::*;

   localparam int       SHIFT_DOWN = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
   localparam int       SHIFT_UP   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam word_type FRAC_MASK  = word_type'((64'd1 << FRAC_BITS) - 64'd1);

   function automatic q16_type to_q16(input word_type w);
      word_type f;
      f = w & FRAC_MASK;
      return q16_type'((f >> SHIFT_DOWN) << SHIFT_UP);
   endfunction

   logic                 accept;
   logic [LATENCY-1:0]   vld_ff;

   // stage 1
   word_type    ix, iy;
   q16_type     tx, ty;
   logic [63:0] px_prod, py_prod;
   word_type    px_ff, py_ff, seed_ff;
   logic [31:0] ttx_ff, tty_ff;
   logic [17:0] kx_ff, ky_ff;

   // stage 2
   logic [49:0] ex_prod, ey_prod;
   q16_type     sx_ff, sy_ff;

   // stages 3 to 5
   q16_ext_type sx_e, sy_e, rx, ry;
   weight_type  w_in [NUM_CORNERS];
   weight_type  w3_ff [NUM_CORNERS];
   weight_type  w4_ff [NUM_CORNERS];
   weight_type  w5_ff [NUM_CORNERS];

   // corner hashes
   word_type    px_sel [NUM_CORNERS];
   word_type    py_sel [NUM_CORNERS];
   value_type   corner_val [NUM_CORNERS];

   // stages 6 to 8
   term_type          term_ff [NUM_CORNERS];
   logic [56:0]       pair_ff [2];
   logic [57:0]       total_in;
   value_type         noise_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LATENCY-2:0], accept};
      end
   end

   // floor toward minus infinity and fraction in Q0.16
   assign ix      = word_type'(req_x_coord >>> FRAC_BITS);
   assign iy      = word_type'(req_y_coord >>> FRAC_BITS);
   assign tx      = to_q16(word_type'(req_x_coord));
   assign ty      = to_q16(word_type'(req_y_coord));
   assign px_prod = 64'(ix) * 64'(HASH_MUL_X);
   assign py_prod = 64'(iy) * 64'(HASH_MUL_Y);

   always_ff @(posedge clock) begin
      px_ff   <= px_prod[31:0];
      py_ff   <= py_prod[31:0];
      seed_ff <= req_seed_word;
      ttx_ff  <= 32'(tx) * 32'(tx);
      tty_ff  <= 32'(ty) * 32'(ty);
      kx_ff   <= Q16_THREE - {1'b0, tx, 1'b0};
      ky_ff   <= Q16_THREE - {1'b0, ty, 1'b0};
   end

   // easing t*t*(3-2t), top bits of the product
   assign ex_prod = 50'(ttx_ff) * 50'(kx_ff);
   assign ey_prod = 50'(tty_ff) * 50'(ky_ff);

   always_ff @(posedge clock) begin
      sx_ff <= ex_prod[47:32];
      sy_ff <= ey_prod[47:32];
   end

   assign sx_e = {1'b0, sx_ff};
   assign sy_e = {1'b0, sy_ff};
   assign rx   = Q16_ONE - sx_e;
   assign ry   = Q16_ONE - sy_e;

   always_comb begin
      w_in[0] = weight_type'(34'(rx)   * 34'(ry));
      w_in[1] = weight_type'(34'(sx_e) * 34'(ry));
      w_in[2] = weight_type'(34'(rx)   * 34'(sy_e));
      w_in[3] = weight_type'(34'(sx_e) * 34'(sy_e));
   end

   // weights wait for the hash pipeline
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         w3_ff[i] <= w_in[i];
         w4_ff[i] <= w3_ff[i];
         w5_ff[i] <= w4_ff[i];
      end
   end

   // corner +1 steps fold into the hash products: (i+1)*c = i*c + c
   assign px_sel[0] = px_ff;
   assign px_sel[1] = px_ff + HASH_MUL_X;
   assign px_sel[2] = px_ff;
   assign px_sel[3] = px_ff + HASH_MUL_X;
   assign py_sel[0] = py_ff;
   assign py_sel[1] = py_ff;
   assign py_sel[2] = py_ff + HASH_MUL_Y;
   assign py_sel[3] = py_ff + HASH_MUL_Y;

   for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_corner
      vn2d_hash u_hash (
         .clock        (clock),
         .px_term      (px_sel[c]),
         .py_term      (py_sel[c]),
         .seed         (seed_ff),
         .corner_value (corner_val[c])
      );
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         term_ff[i] <= term_type'(57'(corner_val[i]) * 57'(w5_ff[i]));
      end
      pair_ff[0] <= 57'(term_ff[0]) + 57'(term_ff[1]);
      pair_ff[1] <= 57'(term_ff[2]) + 57'(term_ff[3]);
      noise_ff   <= total_in[55:32];
   end

   // weights sum to 2^32, so the total stays below 2^56
   assign total_in = 58'(pair_ff[0]) + 58'(pair_ff[1]);

   assign rsp_valid       = vld_ff[LATENCY-1];
   assign rsp_noise_value = noise_ff;

endmodule

>>> verif/tb_value_noise_2d_unit.sv
// self-checking testbench of value_noise_2d_unit: directed corner points, then random bursts
// depends on vn2d_pkg and the value_noise_2d_unit rtl; predicts every sample in the testbench
module tb_value_noise_2d_unit;

   localparam int FRAC_BITS = 16;
   localparam logic [31:0] FRAC_MASK = (32'h1 << FRAC_BITS) - 32'h1;
   localparam int RANDOM_POINTS = 450;
   localparam int IDLE_LIMIT = 2000;

   localparam logic [31:0] MUL_X = 32'h9E37_79B9;
   localparam logic [31:0] MUL_Y = 32'h85EB_CA6B;
   localparam logic [31:0] MIX_A = 32'h7FEB_352D;
   localparam logic [31:0] MIX_B = 32'h846C_A68B;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] seed;
      bit          drain;
   } noise_point_type;

   logic                clock;
   logic                reset;
   logic                start = 1'b0;
   logic                busy;
   logic signed [31:0]  req_x_coord = '0;
   logic signed [31:0]  req_y_coord = '0;
   vn2d_pkg::word_type  req_seed_word = '0;
   logic                rsp_valid;
   vn2d_pkg::value_type rsp_noise_value;

   noise_point_type     pending_points[$];
   vn2d_pkg::value_type expected_noise[$];
   noise_point_type     cur_point = '{default: '0};
   bit                  sending = 1'b0;
   logic                item_taken = 1'b0;
   int                  gap_left = 0;
   int                  burst_left = 0;
   int                  taken_count = 0;
   int                  total_items = 0;
   int                  error_count = 0;
   int                  idle_cycles = 0;
   bit                  moved;
   vn2d_pkg::value_type want;

   value_noise_2d_unit #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .req_seed_word  (req_seed_word),
      .rsp_valid      (rsp_valid),
      .rsp_noise_value(rsp_noise_value)
   );

   function automatic logic [31:0] lattice_hash(logic [31:0] ix, logic [31:0] iy,
                                                logic [31:0] seed);
      logic [31:0] h;
      h = seed ^ (ix * MUL_X) ^ (iy * MUL_Y);
      h = h ^ (h >> 16);
      h = h * MIX_A;
      h = h ^ (h >> 15);
      h = h * MIX_B;
      h = h ^ (h >> 16);
      return h;
   endfunction

   // fraction bits brought to q0.16, then eased with t*t*(3-2t)
   function automatic logic [63:0] eased_fraction(logic [31:0] coord);
      logic [63:0] t;
      logic [63:0] k;
      if (FRAC_BITS >= 16) begin
         t = 64'((coord & FRAC_MASK) >> (FRAC_BITS - 16));
      end else begin
         t = 64'((coord & FRAC_MASK) << (16 - FRAC_BITS));
      end
      t = t & 64'hFFFF;
      k = 64'd196608 - 2 * t;
      return ((t * t * k) >> 32) & 64'hFFFF;
   endfunction

   function automatic vn2d_pkg::value_type predict_noise(logic [31:0] x, logic [31:0] y,
                                                         logic [31:0] seed);
      logic [31:0] ix;
      logic [31:0] iy;
      logic [63:0] sx;
      logic [63:0] sy;
      logic [63:0] rx;
      logic [63:0] ry;
      logic [63:0] v00;
      logic [63:0] v10;
      logic [63:0] v01;
      logic [63:0] v11;
      logic [63:0] acc;
      ix = $signed(x) >>> FRAC_BITS;
      iy = $signed(y) >>> FRAC_BITS;
      sx = eased_fraction(x);
      sy = eased_fraction(y);
      rx = 64'd65536 - sx;
      ry = 64'd65536 - sy;
      v00 = 64'(lattice_hash(ix, iy, seed) & 32'hFF_FFFF);
      v10 = 64'(lattice_hash(ix + 32'd1, iy, seed) & 32'hFF_FFFF);
      v01 = 64'(lattice_hash(ix, iy + 32'd1, seed) & 32'hFF_FFFF);
      v11 = 64'(lattice_hash(ix + 32'd1, iy + 32'd1, seed) & 32'hFF_FFFF);
      acc = v00 * (rx * ry) + v10 * (sx * ry) + v01 * (rx * sy) + v11 * (sx * sy);
      return acc[55:32];
   endfunction

   // 0 any word, 1 small integer part, 2 small lattice point, 3 extreme fraction,
   // 4 integer part at the ends of the range
   function automatic logic [31:0] pick_coord(int unsigned kind);
      int          ip;
      logic [31:0] fr;
      fr = $urandom & FRAC_MASK;
      ip = $urandom;
      case (kind)
         0: return $urandom;
         1: ip = $urandom_range(0, 8) - 4;
         2: begin
            ip = $urandom_range(0, 8) - 4;
            fr = '0;
         end
         3: begin
            case ($urandom_range(0, 5))
               0: fr = '0;
               1: fr = 32'd1;
               2: fr = FRAC_MASK >> 1;
               3: fr = (FRAC_MASK >> 1) + 32'd1;
               4: fr = FRAC_MASK - 32'd1;
               default: fr = FRAC_MASK;
            endcase
         end
         default: ip = $urandom_range(0, 1) ? (2 ** (31 - FRAC_BITS)) - 1
                                            : -(2 ** (31 - FRAC_BITS));
      endcase
      return (ip << FRAC_BITS) | fr;
   endfunction

   task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] seed, bit drain);
      noise_point_type p;
      p = '{x, y, seed, drain};
      pending_points = {pending_points, p};
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender: bursts of items separated by random gaps, drain points wait for an empty pipe
   always @(negedge clock) begin
      if (!reset) begin
         if (item_taken) begin
            sending = 1'b0;
         end
         if (!sending) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_points.size() != 0 &&
                         !(pending_points[0].drain && expected_noise.size() != 0)) begin
               cur_point = pending_points.pop_front();
               sending = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end
            end
         end
      end
      start <= sending;
      req_x_coord <= cur_point.x;
      req_y_coord <= cur_point.y;
      req_seed_word <= cur_point.seed;
   end

   // checker and watchdog: results are compared before this edge's item is queued
   always @(posedge clock) begin
      if (reset) begin
         item_taken <= 1'b0;
         idle_cycles = 0;
      end else begin
         moved = 1'b0;
         if (rsp_valid === 1'b1) begin
            moved = 1'b1;
            if (expected_noise.size() == 0) begin
               error_count++;
               $display("%0t: noise result with none pending, expected none, actual %h",
                        $time, rsp_noise_value);
            end else begin
               want = expected_noise.pop_front();
               if (rsp_noise_value !== want) begin
                  error_count++;
                  $display("%0t: noise_value mismatch, expected %h, actual %h",
                           $time, want, rsp_noise_value);
               end
            end
         end else if (rsp_valid !== 1'b0) begin
            error_count++;
            $display("%0t: rsp_valid unknown, expected 0 or 1, actual %b", $time, rsp_valid);
         end
         item_taken <= start && !busy;
         if (start && !busy) begin
            moved = 1'b1;
            expected_noise = {expected_noise,
                              predict_noise(req_x_coord, req_y_coord, req_seed_word)};
            taken_count++;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int unsigned kind;
      int unsigned xk;
      int unsigned yk;
      logic [31:0] seed;
      reset = 1'b1;

      add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_point(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, $urandom, 1'b0);
      add_point(32'h8000_0000, 32'h8000_0000, $urandom, 1'b0);
      add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      add_point(32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0);
      add_point(32'h0000_8000, 32'h0000_8000, 32'h1234_5678, 1'b0);
      add_point(32'hFFFF_8000, 32'h7FFF_0000, 32'h8000_0000, 1'b0);
      add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
      add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      // exact lattice points give zero eased fractions
      add_point(32'h0001_0000, 32'hFFFF_0000, $urandom, 1'b0);
      add_point(32'h0000_0001, 32'h0000_0001, $urandom, 1'b0);
      add_point(32'h1234_5678, 32'h9ABC_DEF0, 32'hDEAD_BEEF, 1'b0);
      add_point(32'hFFFE_0001, 32'h0001_FFFF, 32'hAAAA_AAAA, 1'b0);
      add_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
      add_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
      add_point(32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);

      for (int n = 0; n < RANDOM_POINTS; n++) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            xk = 0;
         end else if (kind < 6) begin
            xk = 1;
         end else begin
            xk = kind - 4;
         end
         yk = (kind == 9) ? $urandom_range(0, 4) : xk;
         case ($urandom_range(0, 15))
            0: seed = 32'h0000_0000;
            1: seed = 32'hFFFF_FFFF;
            default: seed = $urandom;
         endcase
         add_point(pick_coord(xk), pick_coord(yk), seed, n % 150 == 75);
      end
      total_items = pending_points.size();

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      while (taken_count < total_items || expected_noise.size() != 0) begin
         @(negedge clock);
      end
      repeat (vn2d_pkg::LATENCY + 4) @(negedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/vn2d_pkg.sv
rtl/vn2d_hash.sv
rtl/value_noise_2d_unit.sv
verif/tb_value_noise_2d_unit.sv
